### rtl/hce_pkg.sv
// Package: shared constants, codes, command/status types and helpers of the chunked encoder
`default_nettype none
package hce_pkg;

  localparam int BUF_DEPTH_DEFAULT = 256;
  localparam int CAP_W             = 9;
  localparam logic [CAP_W-1:0] CAP_RESET = 9'd256;
  localparam int PADDR_W           = 3;
  localparam int PDATA_W           = 32;
  localparam int OUT_W             = 64;
  localparam int CNT_OUT_W         = 4;

  localparam logic REG_CHUNK_CAPACITY = 1'b0;

  localparam logic [7:0] CHAR_CR   = 8'h0d;
  localparam logic [7:0] CHAR_LF   = 8'h0a;
  localparam logic [7:0] CHAR_ZERO = 8'h30;
  localparam logic [7:0] CHAR_A_OFFSET = 8'h57;

  typedef enum logic [2:0] {
    SRC_HEX,
    SRC_CR,
    SRC_LF,
    SRC_ZERO,
    SRC_DATA
  } byte_src_t;

  typedef struct packed {
    logic      push;
    logic      last;
    byte_src_t src;
    logic [1:0] digit;
    logic      latch;
    logic      store_in;
    logic      store_held;
    logic      clear_fill;
  } cmd_t;

  typedef struct packed {
    logic       flush_need;
    logic       fill_zero;
    logic [1:0] hex_top;
    logic       data_last;
    logic       out_free;
    logic       room_mid;
  } status_t;

  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    logic [7:0] n8;
    n8 = {4'b0000, nib};
    return (nib < 4'd10) ? (CHAR_ZERO + n8) : (CHAR_A_OFFSET + n8);
  endfunction

endpackage
`default_nettype wire

### rtl/hce_if.sv
// Interfaces: body input channel and encoded output channel
`default_nettype none
interface hce_in_if;
  logic       valid;
  logic       ready;
  logic       mode;
  logic [7:0] data_byte;

  modport source (output valid, output mode, output data_byte, input ready);
  modport sink   (input valid, input mode, input data_byte, output ready);
endinterface

interface hce_out_if;
  logic                           valid;
  logic                           ready;
  logic [hce_pkg::OUT_W-1:0]      out_bytes;
  logic [hce_pkg::CNT_OUT_W-1:0]  byte_count;
  logic                           last_of_run;

  modport source (output valid, output out_bytes, output byte_count, output last_of_run,
                  input ready);
  modport sink   (input valid, input out_bytes, input byte_count, input last_of_run,
                  output ready);
endinterface
`default_nettype wire

### rtl/hce_ram.sv
// Generic single-write, single-read RAM with registered read data
`default_nettype none
module hce_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                  clk,
  input  wire logic                  we,
  input  wire logic [ADDR_W-1:0]     waddr,
  input  wire logic [WIDTH-1:0]      wdata,
  input  wire logic [ADDR_W-1:0]     raddr,
  output logic      [WIDTH-1:0]      rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

### rtl/hce_datapath.sv
// Datapath: capacity register, fill count, chunk store, byte selection, packer, output register
`default_nettype none
module hce_datapath #(
  parameter int BUF_DEPTH = hce_pkg::BUF_DEPTH_DEFAULT
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire hce_pkg::cmd_t                 cmd,
  output hce_pkg::status_t                   st,
  input  wire logic [7:0]                    in_byte,
  input  wire logic                          cfg_we,
  input  wire logic [hce_pkg::CAP_W-1:0]     cfg_wdata,
  output logic      [hce_pkg::CAP_W-1:0]     cap,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic      [hce_pkg::OUT_W-1:0]     out_bytes,
  output logic      [hce_pkg::CNT_OUT_W-1:0] byte_count,
  output logic                               last_of_run
);
  localparam int CNT_W  = $clog2(BUF_DEPTH + 1);
  localparam int ADDR_W = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;
  localparam int CAP_W  = hce_pkg::CAP_W;

  logic [CNT_W-1:0]  fill, fill_next;
  logic [ADDR_W-1:0] rd_idx, rd_idx_next, raddr, waddr;
  logic [7:0]        held_byte, rdata, wdata, cur_byte;
  logic              we;
  logic [CAP_W-1:0]  cap_eff, n9;
  logic [3:0]        nib;
  logic [63:0]       acc, merged;
  logic [2:0]        acc_cnt;
  logic              data_push, close;

  always_comb begin
    if (cap == '0) begin
      cap_eff = CAP_W'(1);
    end else if (cap > CAP_W'(BUF_DEPTH)) begin
      cap_eff = CAP_W'(BUF_DEPTH);
    end else begin
      cap_eff = cap;
    end
  end

  assign n9 = CAP_W'(fill);

  always_comb begin
    st.flush_need = (n9 >= cap_eff);
    st.fill_zero  = (fill == '0);
    if (n9[8]) begin
      st.hex_top = 2'd2;
    end else if (n9[7:4] != 4'd0) begin
      st.hex_top = 2'd1;
    end else begin
      st.hex_top = 2'd0;
    end
    st.data_last = (CNT_W'(rd_idx) == (fill - CNT_W'(1)));
    st.out_free  = !out_valid || out_ready;
    st.room_mid  = (acc_cnt != 3'd7);
  end

  always_comb begin
    case (cmd.digit)
      2'd2:    nib = {3'b000, n9[8]};
      2'd1:    nib = n9[7:4];
      default: nib = n9[3:0];
    endcase
  end

  always_comb begin
    case (cmd.src)
      hce_pkg::SRC_HEX:  cur_byte = hce_pkg::hex_char(nib);
      hce_pkg::SRC_CR:   cur_byte = hce_pkg::CHAR_CR;
      hce_pkg::SRC_LF:   cur_byte = hce_pkg::CHAR_LF;
      hce_pkg::SRC_ZERO: cur_byte = hce_pkg::CHAR_ZERO;
      hce_pkg::SRC_DATA: cur_byte = rdata;
      default:           cur_byte = hce_pkg::CHAR_ZERO;
    endcase
  end

  assign data_push = cmd.push && (cmd.src == hce_pkg::SRC_DATA);

  always_comb begin
    if (cmd.src == hce_pkg::SRC_DATA) begin
      rd_idx_next = data_push ? (rd_idx + ADDR_W'(1)) : rd_idx;
    end else begin
      rd_idx_next = '0;
    end
    raddr = rd_idx_next;
  end

  always_comb begin
    we    = cmd.store_in || cmd.store_held;
    waddr = cmd.store_held ? '0 : fill[ADDR_W-1:0];
    wdata = cmd.store_held ? held_byte : in_byte;
    fill_next = fill;
    if (cmd.store_in) begin
      fill_next = fill + CNT_W'(1);
    end else if (cmd.store_held) begin
      fill_next = CNT_W'(1);
    end else if (cmd.clear_fill) begin
      fill_next = '0;
    end
  end

  hce_ram #(
    .WIDTH (8),
    .DEPTH (BUF_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign merged = acc | (64'(cur_byte) << {acc_cnt, 3'b000});
  assign close  = cmd.last || (acc_cnt == 3'd7);

  always_ff @(posedge clk) begin
    if (rst) begin
      cap       <= hce_pkg::CAP_RESET;
      fill      <= '0;
      rd_idx    <= '0;
      acc       <= '0;
      acc_cnt   <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        cap <= cfg_wdata;
      end
      fill   <= fill_next;
      rd_idx <= rd_idx_next;
      if (cmd.push && close) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (cmd.push) begin
        if (close) begin
          out_bytes   <= merged;
          byte_count  <= {1'b0, acc_cnt} + 4'd1;
          last_of_run <= cmd.last;
          acc         <= '0;
          acc_cnt     <= '0;
        end else begin
          acc     <= merged;
          acc_cnt <= acc_cnt + 3'd1;
        end
      end
    end
    if (cmd.latch) begin
      held_byte <= in_byte;
    end
  end
endmodule
`default_nettype wire

### rtl/hce_ctrl.sv
// Controller: sequences chunk headers, stored bytes, trailers and the terminator
`default_nettype none
module hce_ctrl (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  input  wire logic             in_mode,
  output logic                  in_ready,
  input  wire hce_pkg::status_t st,
  output hce_pkg::cmd_t         cmd
);
  typedef enum logic [3:0] {
    IDLE, HEX, CR1, LF1, DATA, CR2, LF2, T0, TCR1, TLF1, TCR2, TLF2, STORE
  } state_t;

  state_t     state, state_next;
  logic [1:0] digit, digit_next;
  logic       pend_data, pend_data_next;
  logic       emit, take;

  always_comb begin
    cmd            = '0;
    cmd.src        = hce_pkg::SRC_ZERO;
    cmd.digit      = digit;
    emit           = 1'b0;
    state_next     = state;
    digit_next     = digit;
    pend_data_next = pend_data;
    in_ready       = (state == IDLE);

    unique case (state)
      IDLE:  ;
      HEX:   begin emit = 1'b1; cmd.src = hce_pkg::SRC_HEX;  end
      CR1:   begin emit = 1'b1; cmd.src = hce_pkg::SRC_CR;   end
      LF1:   begin emit = 1'b1; cmd.src = hce_pkg::SRC_LF;   end
      DATA:  begin emit = 1'b1; cmd.src = hce_pkg::SRC_DATA; end
      CR2:   begin emit = 1'b1; cmd.src = hce_pkg::SRC_CR;   end
      LF2:   begin emit = 1'b1; cmd.src = hce_pkg::SRC_LF; cmd.last = pend_data; end
      T0:    begin emit = 1'b1; cmd.src = hce_pkg::SRC_ZERO; end
      TCR1:  begin emit = 1'b1; cmd.src = hce_pkg::SRC_CR;   end
      TLF1:  begin emit = 1'b1; cmd.src = hce_pkg::SRC_LF;   end
      TCR2:  begin emit = 1'b1; cmd.src = hce_pkg::SRC_CR;   end
      TLF2:  begin emit = 1'b1; cmd.src = hce_pkg::SRC_LF; cmd.last = 1'b1; end
      STORE: ;
      default: ;
    endcase

    take     = emit && (st.out_free || (st.room_mid && !cmd.last));
    cmd.push = take;

    unique case (state)
      IDLE: begin
        if (in_valid) begin
          cmd.latch = 1'b1;
          if (!in_mode) begin
            if (st.flush_need) begin
              pend_data_next = 1'b1;
              digit_next     = st.hex_top;
              state_next     = HEX;
            end else begin
              cmd.store_in = 1'b1;
            end
          end else begin
            pend_data_next = 1'b0;
            digit_next     = st.hex_top;
            state_next     = st.fill_zero ? T0 : HEX;
          end
        end
      end
      HEX: begin
        if (take) begin
          if (digit == 2'd0) begin
            state_next = CR1;
          end else begin
            digit_next = digit - 2'd1;
          end
        end
      end
      CR1:  if (take) state_next = LF1;
      LF1:  if (take) state_next = DATA;
      DATA: if (take && st.data_last) state_next = CR2;
      CR2:  if (take) state_next = LF2;
      LF2: begin
        if (take) begin
          if (pend_data) begin
            state_next = STORE;
          end else begin
            cmd.clear_fill = 1'b1;
            state_next     = T0;
          end
        end
      end
      T0:   if (take) state_next = TCR1;
      TCR1: if (take) state_next = TLF1;
      TLF1: if (take) state_next = TCR2;
      TCR2: if (take) state_next = TLF2;
      TLF2: if (take) state_next = IDLE;
      STORE: begin
        cmd.store_held = 1'b1;
        state_next     = IDLE;
      end
      default: state_next = IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      digit     <= 2'd0;
      pend_data <= 1'b0;
    end else begin
      state     <= state_next;
      digit     <= digit_next;
      pend_data <= pend_data_next;
    end
  end
endmodule
`default_nettype wire

### rtl/http_chunked_encoder_top.sv
// Top level: chunked transfer encoder with APB-style capacity register
`default_nettype none
// Body bytes enter one per request and collect in a chunk store of BUF_DEPTH bytes. A data
// byte that finds room is stored in its accept cycle, so such requests stream at one per
// cycle. A data byte that finds the store at capacity first emits the chunk: the emitter
// produces one byte per cycle (hex length of d = one to three digits, CR LF, n stored bytes
// read through the store's single registered read port, CR LF), packed into eight-byte
// results, and a STORE state then stores the new byte; the next request is accepted only
// after that. A finish request emits any held chunk and then "0" CR LF CR LF, going straight
// to the terminator with an empty store. The emitter waits on the output channel only when
// a full result, or the last result of a request, meets an output register that is occupied
// and not being taken. The store needs no clearing after reset; capacity is register 0 at
// byte address 0, reset value 256.
module http_chunked_encoder_top #(
  parameter int BUF_DEPTH = hce_pkg::BUF_DEPTH_DEFAULT
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  hce_in_if.sink                             body,
  hce_out_if.source                          stream,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [hce_pkg::PADDR_W-1:0]   paddr,
  input  wire logic [hce_pkg::PDATA_W-1:0]   pwdata,
  output logic      [hce_pkg::PDATA_W-1:0]   prdata,
  output logic                               pready
);
  hce_pkg::cmd_t               cmd;
  hce_pkg::status_t            st;
  logic                        cfg_hit, cfg_we;
  logic [hce_pkg::CAP_W-1:0]   cap;

  assign cfg_hit = (paddr[2] == hce_pkg::REG_CHUNK_CAPACITY);
  assign cfg_we  = psel && penable && pwrite && cfg_hit;
  assign pready  = 1'b1;
  assign prdata  = cfg_hit ? hce_pkg::PDATA_W'(cap) : '0;

  hce_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (body.valid),
    .in_mode  (body.mode),
    .in_ready (body.ready),
    .st       (st),
    .cmd      (cmd)
  );

  hce_datapath #(
    .BUF_DEPTH (BUF_DEPTH)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .st          (st),
    .in_byte     (body.data_byte),
    .cfg_we      (cfg_we),
    .cfg_wdata   (pwdata[hce_pkg::CAP_W-1:0]),
    .cap         (cap),
    .out_valid   (stream.valid),
    .out_ready   (stream.ready),
    .out_bytes   (stream.out_bytes),
    .byte_count  (stream.byte_count),
    .last_of_run (stream.last_of_run)
  );
endmodule
`default_nettype wire

### rtl/hce_checker.sv
// Checker: port-level assertions for the chunked encoder, bound to the top level
`default_nettype none
module hce_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        in_mode,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [63:0] out_bytes,
  input wire logic [3:0]  byte_count,
  input wire logic        last_of_run
);
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_bytes) && $stable(byte_count)
                                && $stable(last_of_run))
    else $error("stalled result changed");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (byte_count != 4'd0) && (byte_count <= 4'd8))
    else $error("byte count out of range");

  a_full_groups: assert property (@(posedge clk) disable iff (rst)
    out_valid && !last_of_run |-> byte_count == 4'd8)
    else $error("short result before end of run");

  a_finish_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && in_mode |=> !in_ready)
    else $error("finish request did not hold off input");

  a_reset_clear: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result pending after reset");
endmodule

bind http_chunked_encoder_top hce_checker u_hce_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (body.valid),
  .in_ready    (body.ready),
  .in_mode     (body.mode),
  .out_valid   (stream.valid),
  .out_ready   (stream.ready),
  .out_bytes   (stream.out_bytes),
  .byte_count  (stream.byte_count),
  .last_of_run (stream.last_of_run)
);
`default_nettype wire

### test/hce_check_pkg.sv
// Scoreboard for the chunked encoder: predicted encoded words and their comparison
package hce_check_pkg;
  import hce_pkg::*;

  localparam int STORE_DEPTH = BUF_DEPTH_DEFAULT;
  localparam int REPORT_LIMIT = 10;
  localparam logic MODE_DATA = 1'b0;
  localparam logic MODE_FINISH = 1'b1;
  localparam logic [7:0] CHAR_LOWER_A = 8'h61;

  typedef struct packed {
    logic [OUT_W-1:0]     bytes_w;
    logic [CNT_OUT_W-1:0] count;
    logic                 last;
  } enc_word_t;

  class chunk_scoreboard;
    logic [7:0]       held [STORE_DEPTH];
    int unsigned      fill;
    logic [CAP_W-1:0] capacity;
    logic [7:0]       wire_bytes [$];
    enc_word_t        awaited [$];
    int unsigned      errors;
    int unsigned      words_checked;
    int unsigned      requests_noted;

    function new();
      fill = 0;
      capacity = CAP_RESET;
      errors = 0;
      words_checked = 0;
      requests_noted = 0;
    endfunction

    function void set_capacity(input logic [CAP_W-1:0] value);
      capacity = value;
    endfunction

    function int unsigned pending();
      return awaited.size();
    endfunction

    function void flag(input string what);
      errors++;
      if (errors <= REPORT_LIMIT) $display("MISMATCH: %s", what);
    endfunction

    function void emit_chunk();
      logic [3:0] nib;
      bit started;
      if (fill == 0) return;
      started = 1'b0;
      for (int sh = 8; sh >= 0; sh -= 4) begin
        nib = 4'((fill >> sh) & 15);
        if (nib != 0 || started || sh == 0) begin
          started = 1'b1;
          wire_bytes.push_back(nib < 10 ? CHAR_ZERO + 8'(nib) : CHAR_LOWER_A + 8'(nib) - 8'd10);
        end
      end
      wire_bytes.push_back(CHAR_CR);
      wire_bytes.push_back(CHAR_LF);
      for (int unsigned i = 0; i < fill; i++) wire_bytes.push_back(held[i]);
      wire_bytes.push_back(CHAR_CR);
      wire_bytes.push_back(CHAR_LF);
      fill = 0;
    endfunction

    function void note_request(input logic mode, input logic [7:0] data_byte);
      int unsigned limit;
      int unsigned k;
      enc_word_t w;
      requests_noted++;
      limit = (capacity == 0) ? 1 : ((capacity > STORE_DEPTH) ? STORE_DEPTH : capacity);
      wire_bytes.delete();
      if (mode == MODE_DATA) begin
        if (fill >= limit) emit_chunk();
        if (fill < STORE_DEPTH) begin
          held[fill] = data_byte;
          fill++;
        end
      end else begin
        emit_chunk();
        wire_bytes.push_back(CHAR_ZERO);
        wire_bytes.push_back(CHAR_CR);
        wire_bytes.push_back(CHAR_LF);
        wire_bytes.push_back(CHAR_CR);
        wire_bytes.push_back(CHAR_LF);
      end
      w = '0;
      k = 0;
      foreach (wire_bytes[i]) begin
        w.bytes_w[8*k +: 8] = wire_bytes[i];
        k++;
        if (k == 8 || i == wire_bytes.size() - 1) begin
          w.count = CNT_OUT_W'(k);
          w.last = (i == wire_bytes.size() - 1);
          awaited.push_back(w);
          w = '0;
          k = 0;
        end
      end
    endfunction

    function void check_word(input logic [OUT_W-1:0] bytes_w, input logic [CNT_OUT_W-1:0] count,
                             input logic last);
      enc_word_t want;
      words_checked++;
      if (awaited.size() == 0) begin
        flag($sformatf("unexpected word %h count %0d last %0b", bytes_w, count, last));
        return;
      end
      want = awaited.pop_front();
      if (bytes_w !== want.bytes_w)
        flag($sformatf("word %0d bytes: expected %h, got %h", words_checked, want.bytes_w, bytes_w));
      if (count !== want.count)
        flag($sformatf("word %0d count: expected %0d, got %0d", words_checked, want.count, count));
      if (last !== want.last)
        flag($sformatf("word %0d last: expected %0b, got %0b", words_checked, want.last, last));
    endfunction

    function void close_out();
      if (awaited.size() != 0) flag($sformatf("%0d words never arrived", awaited.size()));
    endfunction
  endclass
endpackage

### test/tb.sv
// Testbench top: drives body requests and capacity writes, checks the encoded word stream
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import hce_pkg::*;
  import hce_check_pkg::*;

  localparam int SETTLE_CYCLES = 16;
  localparam int HOLD_CYCLES = 250;
  localparam int CYCLE_LIMIT = 2000000;
  localparam logic [PADDR_W-1:0] CAP_ADDR = PADDR_W'(4 * int'(REG_CHUNK_CAPACITY));
  localparam logic [PADDR_W-1:0] STRAY_ADDR = PADDR_W'(4 * (int'(REG_CHUNK_CAPACITY) + 1));

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel, penable, pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata, prdata;
  logic pready;

  bit calm_in = 1'b0;
  bit calm_out = 1'b0;
  bit took_word = 1'b0;
  bit hold_request = 1'b0;
  bit long_hold = 1'b0;
  int unsigned out_gap = 0;
  int unsigned cycles = 0;
  int unsigned settings_used = 0;

  chunk_scoreboard board = new();

  hce_in_if in_ch();
  hce_out_if out_ch();

  http_chunked_encoder_top i_dut (
    .clk    (clk),
    .rst    (rst),
    .body   (in_ch),
    .stream (out_ch),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_ch.valid && out_ch.ready) begin
      board.check_word(out_ch.out_bytes, out_ch.byte_count, out_ch.last_of_run);
      took_word = 1'b1;
    end
  end

  always @(negedge clk) begin
    if (took_word) begin
      took_word = 1'b0;
      out_gap = calm_out ? 0 : $urandom_range(0, 12);
    end
    if (out_gap > 0) begin
      out_gap--;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= !long_hold;
    end
  end

  initial forever begin
    @(posedge clk);
    if (hold_request) begin
      hold_request = 1'b0;
      long_hold = 1'b1;
      repeat (HOLD_CYCLES) @(posedge clk);
      long_hold = 1'b0;
    end
  end

  task automatic put_request(input logic m, input logic [7:0] d);
    int unsigned gap;
    gap = calm_in ? 0 : $urandom_range(0, 12);
    @(negedge clk);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.mode <= m;
    in_ch.data_byte <= d;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    board.note_request(m, d);
  endtask

  task automatic settle();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic apb_write(input logic [PADDR_W-1:0] addr, input logic [PDATA_W-1:0] data);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic set_capacity(input logic [CAP_W-1:0] value);
    logic [PDATA_W-1:0] got;
    apb_write(CAP_ADDR, PDATA_W'(value));
    board.set_capacity(value);
    settings_used++;
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    paddr <= CAP_ADDR;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    got = prdata;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    if (got[CAP_W-1:0] !== value)
      board.flag($sformatf("capacity readback: expected %0d, got %0d", value, got[CAP_W-1:0]));
  endtask

  task automatic run_phase(input logic [CAP_W-1:0] cap, input int unsigned count,
                           input int unsigned finish_one_in, input bit squeeze);
    logic m;
    set_capacity(cap);
    calm_in = squeeze || ($urandom_range(0, 3) == 0);
    calm_out = ($urandom_range(0, 3) == 0);
    if (squeeze) hold_request = 1'b1;
    for (int unsigned n = 0; n < count; n++) begin
      m = (finish_one_in != 0 && $urandom_range(1, finish_one_in) == 1) ? MODE_FINISH : MODE_DATA;
      put_request(m, 8'($urandom_range(0, 255)));
      if ($urandom_range(0, 39) == 0) settle();
    end
    put_request(MODE_FINISH, 8'($urandom_range(0, 255)));
    settle();
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.mode = MODE_DATA;
    in_ch.data_byte = '0;
    out_ch.ready = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // terminator alone, then a short chunk at the reset capacity
    put_request(MODE_FINISH, 8'hFF);
    put_request(MODE_DATA, 8'h00);
    put_request(MODE_DATA, 8'hFF);
    put_request(MODE_DATA, 8'($urandom_range(0, 255)));
    put_request(MODE_FINISH, 8'h00);
    settle();

    set_capacity('0);
    put_request(MODE_DATA, 8'h5A);
    put_request(MODE_DATA, 8'h81);
    put_request(MODE_FINISH, 8'h3C);
    settle();

    // full chunk with a letter length, then capacity lowered below the fill
    set_capacity(CAP_W'(11));
    repeat (14) put_request(MODE_DATA, 8'($urandom_range(0, 255)));
    settle();
    set_capacity(CAP_W'(2));
    apb_write(STRAY_ADDR, PDATA_W'(100));
    repeat (3) put_request(MODE_DATA, 8'($urandom_range(0, 255)));
    put_request(MODE_FINISH, 8'($urandom_range(0, 255)));
    settle();

    run_phase(CAP_W'(1), 16, 4, 1'b0);
    run_phase('0, 12, 4, 1'b0);
    run_phase(CAP_W'(5), 30, 10, 1'b1);
    run_phase(CAP_W'($urandom_range(10, 15)), 30, 8, 1'b0);
    run_phase(CAP_W'($urandom_range(16, 255)), 30, 12, 1'b0);
    run_phase('1, 257, 0, 1'b0);

    board.close_out();
    $display("Run covered %0d body requests over %0d capacity settings, %0d encoded words checked",
             board.requests_noted, settings_used, board.words_checked);
    if (board.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule
